### hw/rtl/mct_pkg.sv
// mct_pkg: shared types and constants for the category transition block
// no dependencies; imported by mct_ctrl, mct_dp and markov_category_transition
`timescale 1ns / 1ps
`default_nettype none

package mct_pkg;

	// table size and probability fraction bits, fixed by the item and result fields
	localparam int MAX_CATEGORIES = 16;
	localparam int PROB_BITS      = 16;

	localparam int OP_W       = 2;
	localparam int IDX_W      = 4;
	localparam int LABEL_W    = 32;
	localparam int PROB_W     = 17;
	localparam int DRAW_W     = 16;
	localparam int ST_W       = 2;
	localparam int NUM_W      = 5;
	localparam int TOL_W      = 16;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;
	localparam int RES_W      = 2;

	// opcodes
	localparam logic [OP_W-1:0] OP_LABEL = 2'd0;
	localparam logic [OP_W-1:0] OP_PROB  = 2'd1;
	localparam logic [OP_W-1:0] OP_MOVE  = 2'd2;
	localparam logic [OP_W-1:0] OP_NONE  = 2'd3;

	// result status codes
	localparam logic [ST_W-1:0] ST_OK         = 2'd0;
	localparam logic [ST_W-1:0] ST_PROB_RANGE = 2'd1;
	localparam logic [ST_W-1:0] ST_ROW_SUM    = 2'd2;
	localparam logic [ST_W-1:0] ST_INDEX      = 2'd3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_NUM_CATEGORIES = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SUM_TOLERANCE  = 1'd1;

	localparam logic [NUM_W-1:0] NUM_RESET = 5'd2;
	localparam logic [TOL_W-1:0] TOL_RESET = 16'd0;

	// result register source select
	localparam logic [RES_W-1:0] RES_STATUS = 2'd0;
	localparam logic [RES_W-1:0] RES_SUM    = 2'd1;
	localparam logic [RES_W-1:0] RES_PASS   = 2'd2;
	localparam logic [RES_W-1:0] RES_LABEL  = 2'd3;

	// label ram read address select
	localparam logic LRD_CNT = 1'b0;
	localparam logic LRD_SEL = 1'b1;

	// table ram read address select
	localparam logic TRD_PREV = 1'b0;
	localparam logic TRD_SCAN = 1'b1;

	typedef struct packed {
		logic [OP_W-1:0]           opcode;
		logic [IDX_W-1:0]          from_index;
		logic [IDX_W-1:0]          to_index;
		logic signed [LABEL_W-1:0] label_value;
		logic [PROB_W-1:0]         probability;
		logic [DRAW_W-1:0]         random_draw;
	} mct_item_t;

	typedef struct packed {
		logic signed [LABEL_W-1:0] new_label;
		logic                      matched;
		logic [ST_W-1:0]           status;
	} mct_result_t;

	typedef struct packed {
		logic             capture;
		logic             lab_we;
		logic             lab_re;
		logic             lab_rd_sel;
		logic             tab_we;
		logic             tab_re;
		logic             tab_rd_sel;
		logic             cnt_clr;
		logic             cnt_inc;
		logic             lscan;
		logic             tscan;
		logic             tscan_init;
		logic             res_ld;
		logic [RES_W-1:0] res_sel;
		logic [ST_W-1:0]  res_status;
		logic             out_ld;
	} mct_cmd_t;

	typedef struct packed {
		logic [OP_W-1:0] opcode;
		logic            idx_err;
		logic            prob_err;
		logic            to_zero;
		logic            n_one;
		logic            cnt_last_lab;
		logic            cnt_last_tab;
		logic            found_nx;
		logic            hit_now;
		logic            out_free;
	} mct_sts_t;

endpackage

`default_nettype wire

### hw/rtl/mct_ram.sv
// mct_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module mct_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

### hw/rtl/mct_ctrl.sv
// mct_ctrl: sequencing state machine for the category transition block
// depends on mct_pkg (command and status structs, opcodes, codes)
`timescale 1ns / 1ps
`default_nettype none

module mct_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_ready,
	input  mct_pkg::mct_sts_t  sts,
	output mct_pkg::mct_cmd_t  cmd
);

	import mct_pkg::*;

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_DECODE = 4'd1;
	localparam logic [3:0] S_LSCAN  = 4'd2;
	localparam logic [3:0] S_LDRAIN = 4'd3;
	localparam logic [3:0] S_TSCAN  = 4'd4;
	localparam logic [3:0] S_TDRAIN = 4'd5;
	localparam logic [3:0] S_LREAD  = 4'd6;
	localparam logic [3:0] S_LWAIT  = 4'd7;
	localparam logic [3:0] S_PSUM   = 4'd8;
	localparam logic [3:0] S_EMIT   = 4'd9;

	logic [3:0] state_q;
	logic [3:0] state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		cmd        = '0;
		state_d    = state_q;
		item_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_DECODE;
				end
			end
			S_DECODE: begin
				unique case (sts.opcode)
					OP_LABEL: begin
						cmd.res_ld  = 1'b1;
						cmd.res_sel = RES_STATUS;
						if (sts.idx_err) begin
							cmd.res_status = ST_INDEX;
						end else begin
							cmd.lab_we     = 1'b1;
							cmd.res_status = ST_OK;
						end
						state_d = S_EMIT;
					end
					OP_PROB: begin
						if (sts.idx_err) begin
							cmd.res_ld     = 1'b1;
							cmd.res_sel    = RES_STATUS;
							cmd.res_status = ST_INDEX;
							state_d        = S_EMIT;
						end else if (sts.prob_err) begin
							cmd.res_ld     = 1'b1;
							cmd.res_sel    = RES_STATUS;
							cmd.res_status = ST_PROB_RANGE;
							state_d        = S_EMIT;
						end else begin
							// fetch the previous column's running sum
							cmd.tab_re     = !sts.to_zero;
							cmd.tab_rd_sel = TRD_PREV;
							state_d        = S_PSUM;
						end
					end
					OP_MOVE: begin
						cmd.cnt_clr = 1'b1;
						state_d     = S_LSCAN;
					end
					OP_NONE: begin
						cmd.res_ld     = 1'b1;
						cmd.res_sel    = RES_STATUS;
						cmd.res_status = ST_OK;
						state_d        = S_EMIT;
					end
					default: begin
						state_d = S_IDLE;
					end
				endcase
			end
			S_LSCAN: begin
				cmd.lab_re     = 1'b1;
				cmd.lab_rd_sel = LRD_CNT;
				cmd.lscan      = 1'b1;
				cmd.cnt_inc    = 1'b1;
				if (sts.cnt_last_lab) begin
					state_d = S_LDRAIN;
				end
			end
			S_LDRAIN: begin
				if (sts.found_nx) begin
					cmd.tscan_init = 1'b1;
					cmd.cnt_clr    = 1'b1;
					state_d        = sts.n_one ? S_LREAD : S_TSCAN;
				end else begin
					cmd.res_ld  = 1'b1;
					cmd.res_sel = RES_PASS;
					state_d     = S_EMIT;
				end
			end
			S_TSCAN: begin
				cmd.tab_re     = 1'b1;
				cmd.tab_rd_sel = TRD_SCAN;
				cmd.tscan      = 1'b1;
				cmd.cnt_inc    = 1'b1;
				if (sts.hit_now) begin
					state_d = S_LREAD;
				end else if (sts.cnt_last_tab) begin
					state_d = S_TDRAIN;
				end
			end
			S_TDRAIN: begin
				state_d = S_LREAD;
			end
			S_LREAD: begin
				cmd.lab_re     = 1'b1;
				cmd.lab_rd_sel = LRD_SEL;
				state_d        = S_LWAIT;
			end
			S_LWAIT: begin
				cmd.res_ld  = 1'b1;
				cmd.res_sel = RES_LABEL;
				state_d     = S_EMIT;
			end
			S_PSUM: begin
				cmd.tab_we  = 1'b1;
				cmd.res_ld  = 1'b1;
				cmd.res_sel = RES_SUM;
				state_d     = S_EMIT;
			end
			S_EMIT: begin
				if (sts.out_free) begin
					cmd.out_ld = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

### hw/rtl/mct_dp.sv
// mct_dp: datapath with config registers, label and cumulative rams, scan compare
// and output register; depends on mct_pkg and mct_ram
`timescale 1ns / 1ps
`default_nettype none

module mct_dp (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [mct_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [mct_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	input  mct_pkg::mct_item_t               item,
	input  mct_pkg::mct_cmd_t                cmd,
	output mct_pkg::mct_sts_t                sts,
	output mct_pkg::mct_result_t             result,
	output logic                             result_valid,
	input  logic                             result_ready
);

	import mct_pkg::*;

	localparam int LIW    = $clog2(MAX_CATEGORIES);
	localparam int TDEPTH = MAX_CATEGORIES * MAX_CATEGORIES;
	localparam int TAW    = $clog2(TDEPTH);
	localparam int CUMW   = PROB_BITS + 2;
	localparam int SW     = CUMW + 1;
	localparam int XW     = (LIW > NUM_W) ? LIW + 1 : NUM_W + 1;
	localparam int PW     = (CUMW > PROB_W) ? CUMW : PROB_W;
	localparam int DW     = (CUMW > TOL_W) ? CUMW : TOL_W;
	localparam logic [CUMW-1:0] PROB_ONE = CUMW'(1) << PROB_BITS;
	localparam logic [CUMW-1:0] CUM_MAX  = {CUMW{1'b1}};

	// config registers
	logic [NUM_W-1:0] num_q;
	logic [TOL_W-1:0] tol_q;
	logic [NUM_W-1:0] num_wr;

	always_comb begin
		num_wr = cfg_wdata[NUM_W-1:0];
		if (num_wr == '0) begin
			num_wr = NUM_W'(1);
		end else if (XW'(num_wr) > XW'(MAX_CATEGORIES)) begin
			num_wr = NUM_W'(MAX_CATEGORIES);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_q <= NUM_RESET;
			tol_q <= TOL_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_NUM_CATEGORIES: num_q <= num_wr;
				REG_SUM_TOLERANCE:  tol_q <= cfg_wdata[TOL_W-1:0];
				default: ;
			endcase
		end
	end

	// captured item and scan state
	mct_item_t   item_q;
	logic [LIW-1:0] cnt_q;
	logic        found_q;
	logic        hit_q;
	logic        lcmp_s1;
	logic        tcmp_s1;
	logic [LIW-1:0] idx_s1;
	logic [LIW-1:0] row_q;
	logic [LIW-1:0] sel_q;
	mct_result_t res_q;
	mct_result_t out_q;
	logic        out_valid_q;

	logic [XW-1:0]      n_x;
	logic [XW-1:0]      from_x;
	logic [XW-1:0]      to_x;
	logic [XW-1:0]      cnt_x;
	logic [LIW-1:0]     from_row;
	logic [LIW-1:0]     to_col;
	logic [TAW-1:0]     tab_waddr;
	logic [TAW-1:0]     tab_raddr;
	logic [LIW-1:0]     lab_raddr;
	logic [LABEL_W-1:0] lab_wdata;
	logic [LABEL_W-1:0] lab_rdata;
	logic [CUMW-1:0]    tab_rdata;
	logic [CUMW-1:0]    prev_sum;
	logic [SW-1:0]      sum_w;
	logic [CUMW-1:0]    sum_sat;
	logic [CUMW-1:0]    diff;
	logic               to_last;
	logic               sum_err;
	logic               lab_match;
	logic               hit_now;
	logic               idx_err;
	mct_result_t        res_d;

	assign n_x      = XW'(num_q);
	assign from_x   = XW'(item_q.from_index);
	assign to_x     = XW'(item_q.to_index);
	assign cnt_x    = XW'(cnt_q);
	assign from_row = LIW'(item_q.from_index);
	assign to_col   = LIW'(item_q.to_index);
	assign to_last  = (to_x == n_x - XW'(1));

	always_comb begin
		unique case (item_q.opcode)
			OP_LABEL: idx_err = (from_x >= n_x);
			OP_PROB:  idx_err = (from_x >= n_x) || (to_x >= n_x);
			default:  idx_err = 1'b0;
		endcase
	end

	// ram addressing
	assign tab_waddr = TAW'(from_row) * TAW'(MAX_CATEGORIES) + TAW'(to_col);
	assign tab_raddr = (cmd.tab_rd_sel == TRD_SCAN)
		? TAW'(row_q) * TAW'(MAX_CATEGORIES) + TAW'(cnt_q)
		: tab_waddr - TAW'(1);
	assign lab_raddr = (cmd.lab_rd_sel == LRD_SEL) ? sel_q : cnt_q;
	assign lab_wdata = item_q.label_value;

	mct_ram #(
		.WIDTH (LABEL_W),
		.DEPTH (MAX_CATEGORIES)
	) u_lab_ram (
		.clk   (clk),
		.we    (cmd.lab_we),
		.waddr (from_row),
		.wdata (lab_wdata),
		.re    (cmd.lab_re),
		.raddr (lab_raddr),
		.rdata (lab_rdata)
	);

	mct_ram #(
		.WIDTH (CUMW),
		.DEPTH (TDEPTH)
	) u_tab_ram (
		.clk   (clk),
		.we    (cmd.tab_we),
		.waddr (tab_waddr),
		.wdata (sum_sat),
		.re    (cmd.tab_re),
		.raddr (tab_raddr),
		.rdata (tab_rdata)
	);

	// running sum with saturation and row check
	assign prev_sum = (item_q.to_index == '0) ? '0 : tab_rdata;
	assign sum_w    = SW'(prev_sum) + SW'(item_q.probability);
	assign sum_sat  = sum_w[CUMW] ? CUM_MAX : sum_w[CUMW-1:0];
	assign diff     = (sum_sat > PROB_ONE) ? sum_sat - PROB_ONE : PROB_ONE - sum_sat;
	assign sum_err  = to_last && (DW'(diff) > DW'(tol_q));

	// scan compares, one entry per cycle behind the ram read
	assign lab_match = lcmp_s1 && (lab_rdata == item_q.label_value);
	assign hit_now   = tcmp_s1 && !hit_q && (DW'(tab_rdata) > DW'(item_q.random_draw));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			found_q     <= 1'b0;
			hit_q       <= 1'b0;
			lcmp_s1     <= 1'b0;
			tcmp_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			lcmp_s1 <= cmd.lscan;
			tcmp_s1 <= cmd.tscan;
			if (cmd.cnt_clr) begin
				cnt_q <= '0;
			end else if (cmd.cnt_inc) begin
				cnt_q <= cnt_q + LIW'(1);
			end
			if (cmd.capture) begin
				found_q <= 1'b0;
			end else if (lab_match) begin
				found_q <= 1'b1;
			end
			if (cmd.tscan_init) begin
				hit_q <= 1'b0;
			end else if (hit_now) begin
				hit_q <= 1'b1;
			end
			if (cmd.out_ld) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		res_d = '0;
		case (cmd.res_sel)
			RES_STATUS: res_d.status = cmd.res_status;
			RES_SUM:    res_d.status = sum_err ? ST_ROW_SUM : ST_OK;
			RES_PASS: begin
				res_d.new_label = item_q.label_value;
				res_d.status    = ST_OK;
			end
			RES_LABEL: begin
				res_d.new_label = lab_rdata;
				res_d.matched   = 1'b1;
				res_d.status    = ST_OK;
			end
			default: res_d = '0;
		endcase
	end

	// payload registers
	always_ff @(posedge clk) begin
		idx_s1 <= cnt_q;
		if (cmd.capture) begin
			item_q <= item;
		end
		if (lab_match) begin
			row_q <= idx_s1;
		end
		if (cmd.tscan_init) begin
			sel_q <= LIW'(num_q - NUM_W'(1));
		end else if (hit_now) begin
			sel_q <= idx_s1;
		end
		if (cmd.res_ld) begin
			res_q <= res_d;
		end
		if (cmd.out_ld) begin
			out_q <= res_q;
		end
	end

	assign sts.opcode       = item_q.opcode;
	assign sts.idx_err      = idx_err;
	assign sts.prob_err     = PW'(item_q.probability) > PW'(PROB_ONE);
	assign sts.to_zero      = (item_q.to_index == '0);
	assign sts.n_one        = (num_q == NUM_W'(1));
	assign sts.cnt_last_lab = (cnt_x == n_x - XW'(1));
	assign sts.cnt_last_tab = (cnt_x == n_x - XW'(2));
	assign sts.found_nx     = found_q || lab_match;
	assign sts.hit_now      = hit_now;
	assign sts.out_free     = !out_valid_q || result_ready;

	assign result       = out_q;
	assign result_valid = out_valid_q;

endmodule

`default_nettype wire

### hw/rtl/markov_category_transition.sv
// markov chain category transition by inverse-cdf lookup
// one item at a time: the next input transfer is taken in the cycle after the result loads;
// label match and row scan each read one ram entry per cycle
// reset clears the controller, output valid, num_categories to 2 and sum_tolerance to 0
`timescale 1ns / 1ps
`default_nettype none

module markov_category_transition (
	input  logic                           clk,
	input  logic                           arst_n,
	// configuration writes, no read-back
	input  logic                           cfg_wr_en,
	input  logic [mct_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [mct_pkg::CFG_DATA_W-1:0] cfg_wdata,
	// input item channel
	input  logic                           item_valid,
	output logic                           item_ready,
	input  mct_pkg::mct_item_t             item,
	// result channel
	output logic                           result_valid,
	input  logic                           result_ready,
	output mct_pkg::mct_result_t           result
);

	import mct_pkg::*;

	// command and status between the sequencer and the datapath
	mct_cmd_t cmd;
	mct_sts_t sts;

	// sequencer: takes an item transfer only when idle, walks the label match,
	// the row scan and the final label read for a move, then hands the result
	// to the output register once the previous result transfer has gone
	mct_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.sts        (sts),
		.cmd        (cmd)
	);

	// datapath: config registers, label ram, cumulative table ram, running-sum
	// adder with saturation and row check, draw compare and output register;
	// the label and cumulative rams hold no reset value and must be loaded before use
	mct_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.item         (item),
		.cmd          (cmd),
		.sts          (sts),
		.result       (result),
		.result_valid (result_valid),
		.result_ready (result_ready)
	);

endmodule

`default_nettype wire
